>>> rtl/core/utf8d_pkg.sv
package utf8d_pkg;

  localparam int CpW    = 21;
  localparam int QDepth = 4;
  localparam int QAw    = 2;
  localparam int QCntW  = 3;

  // One decoded result as it is queued and delivered.
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           err;
    logic           last;
  } res_t;

  // Results produced by one byte: n is zero, one or two.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Outcome of decoding a byte as a lead byte.
  typedef struct packed {
    logic           hit;
    res_t           res;
    logic [1:0]     bl;
    logic [CpW-1:0] pp;
  } lead_t;

  function automatic lead_t lead_decode(logic [7:0] b);
    lead_t l;
    l = '0;
    if (!b[7]) begin
      l.hit    = 1'b1;
      l.res.cp = {13'b0, b};
    end else if (b[7:5] == 3'b110) begin
      l.bl = 2'd1;
      l.pp = {10'b0, b[4:0], 6'b0};
    end else if (b[7:4] == 4'b1110) begin
      l.bl = 2'd2;
      l.pp = {5'b0, b[3:0], 12'b0};
    end else if (b[7:3] == 5'b11110) begin
      l.bl = 2'd3;
      l.pp = {b[2:0], 18'b0};
    end else begin
      l.hit     = 1'b1;
      l.res.err = 1'b1;
    end
    return l;
  endfunction

endpackage

>>> rtl/core/utf8d_decode.sv
module utf8d_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        byte_in_i,
  input  logic              room_i,
  output utf8d_pkg::push_t  push_o
);

  logic                      in_valid_q, in_valid_d;
  logic [7:0]                byte_q;
  logic [1:0]                bl_q, bl_d;
  logic [utf8d_pkg::CpW-1:0] pp_q, pp_d;
  logic [utf8d_pkg::CpW-1:0] merged;
  logic                      advance;
  logic                      accept;
  logic                      cont;
  utf8d_pkg::lead_t          lead;
  utf8d_pkg::push_t          push;

  assign advance    = in_valid_q & room_i;
  assign in_stall_o = in_valid_q & ~room_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign cont       = (byte_q[7:6] == 2'b10);
  assign lead       = utf8d_pkg::lead_decode(byte_q);
  assign push_o     = push;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // The remaining count selects where the six payload bits land.
  always_comb begin
    unique case (bl_q)
      2'd1:    merged = pp_q | {15'b0, byte_q[5:0]};
      2'd2:    merged = pp_q | {9'b0, byte_q[5:0], 6'b0};
      2'd3:    merged = pp_q | {3'b0, byte_q[5:0], 12'b0};
      default: merged = pp_q;
    endcase
  end

  always_comb begin
    bl_d = bl_q;
    pp_d = pp_q;
    push = '0;
    if (advance) begin
      if (bl_q != 2'd0) begin
        if (cont) begin
          bl_d = bl_q - 2'd1;
          if (bl_q == 2'd1) begin
            push.n  = 2'd1;
            push.r0 = '{cp: merged, err: 1'b0, last: 1'b1};
            pp_d    = '0;
          end else begin
            pp_d = merged;
          end
        end else begin
          // A broken sequence reports an error, then the word restarts as a lead.
          bl_d    = lead.bl;
          pp_d    = lead.pp;
          push.r0 = '{cp: '0, err: 1'b1, last: ~lead.hit};
          if (lead.hit) begin
            push.n       = 2'd2;
            push.r1      = lead.res;
            push.r1.last = 1'b1;
          end else begin
            push.n = 2'd1;
          end
        end
      end else begin
        bl_d = lead.bl;
        pp_d = lead.pp;
        if (lead.hit) begin
          push.n       = 2'd1;
          push.r0      = lead.res;
          push.r0.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      bl_q       <= 2'd0;
      pp_q       <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      bl_q       <= bl_d;
      pp_q       <= pp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_in_i;
    end
  end

  a_idle_partial_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_q == 2'd0 |-> pp_q == '0)
    else $error("partial code point left over with no sequence pending");

  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n == 2'd2 |-> push.r0.err && !push.r0.last && push.r1.last)
    else $error("two-result word has a malformed first or second result");

  a_push_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n != 2'd0 |-> advance)
    else $error("results pushed without a word moving on");

endmodule

>>> rtl/core/utf8d_outq.sv
module utf8d_outq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  utf8d_pkg::push_t          push_i,
  output logic                      room_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [utf8d_pkg::CpW-1:0] code_point_o,
  output logic                      is_error_o,
  output logic                      last_o
);

  utf8d_pkg::res_t            mem_q [utf8d_pkg::QDepth];
  logic [utf8d_pkg::QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [utf8d_pkg::QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [utf8d_pkg::QCntW-1:0] count_q, count_d;
  logic [utf8d_pkg::QAw-1:0]   wr_ptr_nx;
  logic                        pop;
  utf8d_pkg::res_t             head;

  assign head         = mem_q[rd_ptr_q];
  assign out_valid_o  = (count_q != '0);
  assign code_point_o = head.cp;
  assign is_error_o   = head.err;
  assign last_o       = head.last;
  assign pop          = out_valid_o & ~out_stall_i;
  // A word is only let through when both of its possible results fit.
  assign room_o       = (count_q <= utf8d_pkg::QCntW'(utf8d_pkg::QDepth - 2));
  assign wr_ptr_nx    = wr_ptr_q + utf8d_pkg::QAw'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + utf8d_pkg::QAw'(push_i.n);
    rd_ptr_d = rd_ptr_q + utf8d_pkg::QAw'(pop);
    count_d  = count_q + utf8d_pkg::QCntW'(push_i.n) - utf8d_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= utf8d_pkg::QCntW'(utf8d_pkg::QDepth))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> room_o)
    else $error("results pushed into a queue without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != utf8d_pkg::QCntW'(utf8d_pkg::QDepth) |->
      utf8d_pkg::QAw'(wr_ptr_q - rd_ptr_q) == utf8d_pkg::QAw'(count_q))
    else $error("queue pointers disagree with the count");

endmodule

>>> rtl/core/utf8_stream_decoder.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o  byte_in_i[7:0]
// output    out        out_valid_o / out_stall_i code_point_o[20:0], is_error_o, last_o
//
// One input word is taken per cycle unless in_stall_o holds it off; its results leave
// a four-entry result queue one per cycle while out_stall_i is low.
// A word is held in the input register until its results enter the queue.
// The input register moves on only when the queue has two free entries.
// Reset clears the pending sequence and empties the queue.
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        is_error_o,
  output logic        last_o
);

  utf8d_pkg::push_t push;
  logic             room;

  utf8d_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .room_i     (room),
    .push_o     (push)
  );

  utf8d_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .room_o       (room),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .is_error_o   (is_error_o),
    .last_o       (last_o)
  );

endmodule
